[hw/rtl/eg_pkg.sv]
// ----------------------------------------------------------------------------
// eg_pkg
// Shared types and constants for the Euclidean GCD block: controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package eg_pkg;

  localparam int unsigned EG_WIDTH = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } eg_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture operands
    logic swap;       // (a, b) <= (b, a) when a < b
    logic div_start;  // begin remainder a mod b
    logic div_step;   // one shift-subtract step
    logic res_load;   // move a into the result register
  } eg_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic b_zero;
    logic a_lt_b;
    logic div_last;   // current step is the final one of the remainder
  } eg_status_t;

endpackage

[hw/rtl/eg_dp.sv]
// ----------------------------------------------------------------------------
// eg_dp
// GCD datapath: operand registers, restoring shift-subtract remainder unit
// (one quotient bit per cycle) and the result register.
// ----------------------------------------------------------------------------
module eg_dp #(
  parameter int unsigned WIDTH = eg_pkg::EG_WIDTH
) (
  input  logic               clk_i,
  input  logic [WIDTH-1:0]   operand_a_i,
  input  logic [WIDTH-1:0]   operand_b_i,
  input  eg_pkg::eg_cmd_t    cmd_i,
  output eg_pkg::eg_status_t status_o,
  output logic [WIDTH-1:0]   gcd_value_o
);
  import eg_pkg::*;

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] CntLast = CW'(WIDTH - 1);

  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] q_q, q_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] res_q, res_d;

  logic [WIDTH:0]   r_shift;
  logic [WIDTH:0]   r_sub;
  logic [WIDTH-1:0] r_next;
  logic             last;

  // restoring step: shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    r_shift = {r_q, q_q[WIDTH-1]};
    r_sub   = r_shift - {1'b0, b_q};
    if (r_shift >= {1'b0, b_q}) begin
      r_next = r_sub[WIDTH-1:0];
    end else begin
      r_next = r_shift[WIDTH-1:0];
    end
  end

  assign last = (cnt_q == CntLast);

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    r_d   = r_q;
    q_d   = q_q;
    cnt_d = cnt_q;
    res_d = res_q;
    if (cmd_i.load) begin
      a_d = operand_a_i;
      b_d = operand_b_i;
    end
    if (cmd_i.swap) begin
      a_d = b_q;
      b_d = a_q;
    end
    if (cmd_i.div_start) begin
      q_d   = a_q;
      r_d   = '0;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      r_d   = r_next;
      q_d   = {q_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      // last step closes the Euclid iteration: (a, b) <= (b, a mod b)
      if (last) begin
        a_d = b_q;
        b_d = r_next;
      end
    end
    if (cmd_i.res_load) begin
      res_d = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    r_q   <= r_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign status_o.b_zero   = (b_q == '0);
  assign status_o.a_lt_b   = (a_q < b_q);
  assign status_o.div_last = last;
  assign gcd_value_o       = res_q;

endmodule

[hw/rtl/eg_ctrl.sv]
// ----------------------------------------------------------------------------
// eg_ctrl
// GCD controller: sequences load, swap and remainder steps, and owns the
// output valid flag of the result register.
// ----------------------------------------------------------------------------
module eg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  eg_pkg::eg_status_t status_i,
  output eg_pkg::eg_cmd_t    cmd_o
);
  import eg_pkg::*;

  eg_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.b_zero) begin
          state_d = ST_DONE;
        end else if (status_i.a_lt_b) begin
          // a mod b == a, so the iteration reduces to a swap
          cmd_o.swap = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/euclid_gcd.sv]
// ----------------------------------------------------------------------------
// euclid_gcd
// Greatest common divisor of two unsigned WIDTH-bit operands by the
// remainder form of Euclid's algorithm.
// ----------------------------------------------------------------------------
// One operand pair is processed at a time. After the input transfer, each
// Euclid iteration is one check step followed by WIDTH steps in the
// shift-subtract remainder unit (one quotient bit per cycle); an iteration
// with a < b is a single swap in the check state. A final step moves the
// answer into the output register. The time that a pair takes is set by
// the operand values, through the number of remainder iterations and swaps.
// A finished result sits in its own register, so the next pair is accepted
// while the previous result still waits for its output transfer. If that
// previous result is still unread when the next answer is ready, the block
// holds the answer and keeps its input closed until the output transfer.
module euclid_gcd #(
  parameter int unsigned WIDTH = eg_pkg::EG_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] operand_a_i,
  input  logic [WIDTH-1:0] operand_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] gcd_value_o
);
  import eg_pkg::*;

  eg_cmd_t    cmd;
  eg_status_t status;

  eg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eg_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .gcd_value_o (gcd_value_o)
  );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for euclid_gcd. A queue of operand pairs, directed
// corners first and then random pairs of several shapes, feeds a clocked
// driver. A clocked monitor compares each gcd_value transfer with the value
// that a local Euclid predictor worked out when the pair was accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned W           = eg_pkg::EG_WIDTH;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned RANDOM_PAIRS = 390;
  localparam int unsigned STEADY_LO   = 150;   // no idling on either side here
  localparam int unsigned STEADY_HI   = 230;
  localparam int unsigned HOLD_AT     = 60;    // result count that starts the long stall
  localparam int unsigned HOLD_CYCLES = 2000;  // longer than the slowest pair
  localparam int unsigned SETTLE_CYCLES = 100;
  // Covers the worst pair and the long output stall, with a wide margin.
  localparam int unsigned STALL_LIMIT = 20000;

  typedef logic [W-1:0] opnd_t;

  typedef struct {
    opnd_t a;
    opnd_t b;
    bit    wait_empty;  // hold this pair back until every result is in
  } pair_t;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid;
  logic  in_ready_o;
  opnd_t op_a;
  opnd_t op_b;
  logic  out_valid_o;
  logic  out_ready;
  opnd_t gcd_value_o;

  pair_t       pair_q[$];
  opnd_t       gcd_expected_q[$];
  int unsigned pairs_sent;
  int unsigned results_seen;
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_done;

  euclid_gcd #(
    .WIDTH(W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .operand_a_i(op_a),
    .operand_b_i(op_b),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .gcd_value_o(gcd_value_o)
  );

  // Remainder form of Euclid: (x, y) -> (y, x mod y) until y is zero.
  function automatic opnd_t gcd_of_pair(opnd_t x, opnd_t y);
    opnd_t r;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic bit steady(int unsigned n);
    return (n >= STEADY_LO) && (n < STEADY_HI);
  endfunction

  task automatic add_pair(opnd_t a, opnd_t b, bit wait_empty = 1'b0);
    pair_t p;
    p.a = a;
    p.b = b;
    p.wait_empty = wait_empty;
    pair_q.push_back(p);
  endtask

  task automatic add_random_pair(bit wait_empty);
    opnd_t a;
    opnd_t b;
    opnd_t g;
    int unsigned shape;
    shape = $urandom_range(0, 99);
    if (shape < 40) begin
      a = $urandom();
      b = $urandom();
    end else if (shape < 70) begin
      // shared factor, so the answer is usually well above 1
      g = $urandom_range(1, 65535);
      a = g * opnd_t'($urandom_range(0, 32'hFFFF_FFFF / g));
      b = g * opnd_t'($urandom_range(0, 32'hFFFF_FFFF / g));
    end else if (shape < 85) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else begin
      a = $urandom();
      case ($urandom_range(0, 3))
        0: b = '0;
        1: b = a;
        2: begin
          b = a;
          a = '0;
        end
        default: b = a * opnd_t'($urandom_range(1, 7));
      endcase
    end
    add_pair(a, b, wait_empty);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: presents queued pairs, predicts the gcd on each input transfer.
  always @(posedge clk_i or negedge rst_ni) begin : drv
    pair_t nxt;
    bit    fire;
    bit    take;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      op_a     <= '0;
      op_b     <= '0;
    end else begin
      fire = in_valid && in_ready_o;
      if (fire) begin
        gcd_expected_q.push_back(gcd_of_pair(op_a, op_b));
        pairs_sent++;
      end
      if (!in_valid || fire) begin
        take = pair_q.size() != 0;
        if (take && pair_q[0].wait_empty && gcd_expected_q.size() != 0)
          take = 1'b0;
        if (take && !steady(pairs_sent) && $urandom_range(0, 99) < IDLE_PCT)
          take = 1'b0;
        if (take) begin
          nxt  = pair_q.pop_front();
          op_a <= nxt.a;
          op_b <= nxt.b;
        end
        in_valid <= take;
      end
    end
  end

  // Monitor: checks each output transfer and drives out_ready, including
  // one long stall that backs the block up into its input.
  always @(posedge clk_i or negedge rst_ni) begin : mon
    opnd_t want;
    bit    rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (gcd_expected_q.size() == 0) begin
          $error("unexpected gcd_value transfer: actual %0d", gcd_value_o);
          err_cnt++;
        end else begin
          want = gcd_expected_q.pop_front();
          if (gcd_value_o !== want) begin
            $error("gcd_value mismatch: expected %0d actual %0d", want, gcd_value_o);
            err_cnt++;
          end
        end
        results_seen++;
      end
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = steady(results_seen) || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL euclid_gcd");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    pairs_sent   = 0;
    results_seen = 0;
    err_cnt      = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    hold_done    = 1'b0;

    // corners: zeros, all ones, swaps, worst-case Fibonacci pair, bit patterns
    add_pair(32'h0000_0000, 32'h0000_0000);
    add_pair(32'h1234_5678, 32'h0000_0000);
    add_pair(32'h0000_0000, 32'h9ABC_DEF0);
    add_pair(32'h0000_0001, 32'h0000_0000);
    add_pair(32'h0000_0000, 32'h0000_0001);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'h0000_0001);
    add_pair(32'h0000_0001, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    add_pair(32'd2971215073, 32'd1836311903);
    add_pair(32'd1836311903, 32'd2971215073);
    add_pair(32'h8000_0000, 32'h4000_0000);
    add_pair(32'h8000_0000, 32'hC000_0000);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);
    add_pair(32'd7, 32'd7);
    add_pair(32'd12, 32'd18);
    add_pair(32'd6, 32'd35);
    add_pair(32'd4294967291, 32'd4294967279);
    for (int i = 0; i < RANDOM_PAIRS; i++)
      add_random_pair(i == 100 || i == 300);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_q.size() != 0 || in_valid) @(posedge clk_i);
    while (gcd_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("PASS euclid_gcd");
    end else begin
      $display("FAIL euclid_gcd");
    end
    $finish;
  end

endmodule
